// ----- sv/dfiir_pkg.sv -----
// Package for the second-order direct form II IIR filter.
// Widths, register indexes, sequencer states and multiply-accumulate controls.
// No dependencies.
`default_nettype none

package dfiir_pkg;

    localparam int ORDER     = 2;
    localparam int SAMP_W    = 16;
    localparam int COEF_W    = 18;
    localparam int DELAY_W   = 24;
    localparam int OPA_W     = 44;
    localparam int ACC_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int REG_COUNT = 6;

    localparam logic [CFG_IDX_W-1:0] REG_INV_A0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd5;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd16384;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FB0,
        S_FB1,
        S_FB2,
        S_SCALE,
        S_SAT_W,
        S_FF0,
        S_FF1,
        S_FF2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic en;
        logic load;
        logic sub;
    } t_mac_ctl;

endpackage

`default_nettype wire

// ----- sv/direct_form_two_iir_filter.sv -----
// Second-order direct form II IIR filter, one shared multiply-accumulate unit.
// After accept the sequencer steps through FB0-FB2, SCALE, SAT_W, FF0-FF2 and OUT; OUT posts the result.
// One item at a time: the single multiplier does 7 products per item, and no new input is taken until it is posted.
// Input ready only while idle; a finished result waits in an output register.
// Reset (synchronous, active low): pass-through coefficients, delay line zero, no output.
`default_nettype none

module direct_form_two_iir_filter (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire [15:0]                               s_axis_tdata,  // [15:0] in_sample
    output logic                                     m_axis_tvalid,
    input  wire                                      m_axis_tready,
    output logic [15:0]                              m_axis_tdata,  // [15:0] out_sample
    output logic                                     m_axis_tuser,  // [0] clipped
    input  wire                                      i_cfg_wr_en,
    input  wire [dfiir_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  wire [dfiir_pkg::COEF_W-1:0]              i_cfg_data
);
    import dfiir_pkg::*;

    localparam logic signed [ACC_W-1:0] W_HALF = 64'sd134217728;
    localparam logic signed [ACC_W-1:0] W_MAX  = 64'sd8388607;
    localparam logic signed [ACC_W-1:0] W_MIN  = -64'sd8388608;
    localparam logic signed [ACC_W-1:0] Y_HALF = 64'sd8192;
    localparam logic signed [ACC_W-1:0] Y_MAX  = 64'sd32767;
    localparam logic signed [ACC_W-1:0] Y_MIN  = -64'sd32768;

    t_state r_state;
    t_state n_state;

    logic signed [COEF_W-1:0]  r_coef [REG_COUNT];
    logic signed [DELAY_W-1:0] r_delay [ORDER];
    logic signed [DELAY_W-1:0] d_last;
    logic signed [SAMP_W-1:0]  r_x;
    logic signed [DELAY_W-1:0] r_w;
    logic                      r_clip;
    logic                      r_out_valid;
    logic [SAMP_W-1:0]         r_out_data;
    logic                      r_out_clip;

    t_mac_ctl                  mac_ctl;
    logic signed [OPA_W-1:0]   op_a;
    logic signed [COEF_W-1:0]  op_b;
    logic signed [ACC_W-1:0]   acc;

    logic signed [ACC_W-1:0]   w_round;
    logic signed [DELAY_W-1:0] w_sat;
    logic                      w_clip;
    logic signed [ACC_W-1:0]   y_round;
    logic signed [SAMP_W-1:0]  y_sat;
    logic                      y_clip;
    logic                      out_free;

    dfiir_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_acc  (acc)
    );

    assign d_last   = r_delay[ORDER-1];
    assign out_free = !r_out_valid || m_axis_tready;

    assign w_round = (acc + W_HALF) >>> 28;
    assign y_round = (acc + Y_HALF) >>> 14;

    always_comb begin
        if (w_round > W_MAX) begin
            w_sat  = W_MAX[DELAY_W-1:0];
            w_clip = 1'b1;
        end else if (w_round < W_MIN) begin
            w_sat  = W_MIN[DELAY_W-1:0];
            w_clip = 1'b1;
        end else begin
            w_sat  = w_round[DELAY_W-1:0];
            w_clip = 1'b0;
        end
        if (y_round > Y_MAX) begin
            y_sat  = Y_MAX[SAMP_W-1:0];
            y_clip = 1'b1;
        end else if (y_round < Y_MIN) begin
            y_sat  = Y_MIN[SAMP_W-1:0];
            y_clip = 1'b1;
        end else begin
            y_sat  = y_round[SAMP_W-1:0];
            y_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        mac_ctl       = '0;
        op_a          = '0;
        op_b          = '0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = i_rst_n;
                if (s_axis_tvalid) begin
                    n_state = S_FB0;
                end
            end
            S_FB0: begin
                mac_ctl = '{en: 1'b1, load: 1'b1, sub: 1'b0};
                op_a    = {{(OPA_W-SAMP_W){r_x[SAMP_W-1]}}, r_x};
                op_b    = COEF_ONE;
                n_state = S_FB1;
            end
            S_FB1: begin
                mac_ctl = '{en: 1'b1, load: 1'b0, sub: 1'b1};
                op_a    = {{(OPA_W-DELAY_W){r_delay[0][DELAY_W-1]}}, r_delay[0]};
                op_b    = r_coef[REG_A1];
                n_state = (ORDER > 1) ? S_FB2 : S_SCALE;
            end
            S_FB2: begin
                mac_ctl = '{en: 1'b1, load: 1'b0, sub: 1'b1};
                op_a    = {{(OPA_W-DELAY_W){d_last[DELAY_W-1]}}, d_last};
                op_b    = r_coef[REG_A2];
                n_state = S_SCALE;
            end
            S_SCALE: begin
                mac_ctl = '{en: 1'b1, load: 1'b1, sub: 1'b0};
                op_a    = acc[OPA_W-1:0];
                op_b    = r_coef[REG_INV_A0];
                n_state = S_SAT_W;
            end
            S_SAT_W: begin
                n_state = S_FF0;
            end
            S_FF0: begin
                mac_ctl = '{en: 1'b1, load: 1'b1, sub: 1'b0};
                op_a    = {{(OPA_W-DELAY_W){r_w[DELAY_W-1]}}, r_w};
                op_b    = r_coef[REG_B0];
                n_state = S_FF1;
            end
            S_FF1: begin
                mac_ctl = '{en: 1'b1, load: 1'b0, sub: 1'b0};
                op_a    = {{(OPA_W-DELAY_W){r_delay[0][DELAY_W-1]}}, r_delay[0]};
                op_b    = r_coef[REG_B1];
                n_state = (ORDER > 1) ? S_FF2 : S_OUT;
            end
            S_FF2: begin
                mac_ctl = '{en: 1'b1, load: 1'b0, sub: 1'b0};
                op_a    = {{(OPA_W-DELAY_W){d_last[DELAY_W-1]}}, d_last};
                op_b    = r_coef[REG_B2];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[REG_INV_A0] <= COEF_ONE;
            r_coef[REG_A1]     <= '0;
            r_coef[REG_A2]     <= '0;
            r_coef[REG_B0]     <= COEF_ONE;
            r_coef[REG_B1]     <= '0;
            r_coef[REG_B2]     <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index < CFG_IDX_W'(REG_COUNT))) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER; i++) begin
                r_delay[i] <= '0;
            end
            r_out_valid <= 1'b0;
            r_clip      <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_clip <= 1'b0;
                    end
                end
                S_SAT_W: begin
                    r_clip <= w_clip;
                end
                S_OUT: begin
                    if (out_free) begin
                        for (int i = ORDER - 1; i > 0; i--) begin
                            r_delay[i] <= r_delay[i-1];
                        end
                        r_delay[0] <= r_w;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_x <= s_axis_tdata;
        end
        if (r_state == S_SAT_W) begin
            r_w <= w_sat;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_data <= y_sat;
            r_out_clip <= r_clip || y_clip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_clip;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == S_FB0 && !r_clip)
        else $error("accepted item did not start the sequence");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && out_free |=> m_axis_tvalid && r_state == S_IDLE)
        else $error("finished item not posted to output");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !out_free |=> r_state == S_OUT && $stable(r_w))
        else $error("result lost while output stalled");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FB0 |-> ##8 !s_axis_tready || ORDER < 2)
        else $error("input ready during item processing");

endmodule

`default_nettype wire

// ----- sv/dfiir_mac.sv -----
// Shared signed multiply-accumulate unit of the IIR filter.
// One 44 x 18 product per cycle while enabled, loaded, added to or subtracted from the accumulator.
// Depends on dfiir_pkg.
`default_nettype none

module dfiir_mac (
    input  wire                                     i_clk,
    input  wire dfiir_pkg::t_mac_ctl                i_ctl,
    input  wire logic signed [dfiir_pkg::OPA_W-1:0]  i_op_a,
    input  wire logic signed [dfiir_pkg::COEF_W-1:0] i_op_b,
    output logic signed [dfiir_pkg::ACC_W-1:0]      o_acc
);
    import dfiir_pkg::*;

    localparam int PROD_W = OPA_W + COEF_W;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    assign prod     = i_op_a * i_op_b;
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    always_comb begin
        if (i_ctl.load) begin
            n_acc = prod_ext;
        end else if (i_ctl.sub) begin
            n_acc = r_acc - prod_ext;
        end else begin
            n_acc = r_acc + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ----- tb/sv/direct_form_two_iir_filter_tb.sv -----
// Self-checking testbench for the second-order direct form II IIR filter.
// Drives samples and coefficient writes and checks each output item against a directed
// expected value or an in-bench fixed-point filter model. Depends on dfiir_pkg and the RTL top.
`timescale 1ns / 100ps

module direct_form_two_iir_filter_tb;
    import dfiir_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_PAUSE    = 14;
    localparam int TAIL_CYCLES    = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 50;
    localparam int MAX_REPORTS    = 10;

    localparam int STYLE_FULL = 0;
    localparam int STYLE_MILD = 1;
    localparam int STYLE_EDGE = 2;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(REG_COUNT);
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = CFG_IDX_W'(REG_COUNT + 1);

    localparam longint W_MAX = 64'sd8388607;
    localparam longint W_MIN = -64'sd8388608;
    localparam longint Y_MAX = 64'sd32767;
    localparam longint Y_MIN = -64'sd32768;

    typedef struct packed {
        logic [SAMP_W-1:0] sample;
        logic              clip;
    } t_result;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [COEF_W-1:0]    val;
        logic [SAMP_W-1:0]    smp;
        logic                 has_exp;
        t_result              exp;
    } t_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // [15:0] in_sample
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;   // [15:0] out_sample
    logic                 m_axis_tuser;   // [0] clipped
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COEF_W-1:0]    i_cfg_data;

    longint  coef_reg [REG_COUNT];
    longint  dly_line [ORDER];
    t_result expected_results [$];
    t_step   dir_tbl [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_req       = 0;
    int hold_done      = 0;
    int err_cnt        = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int clips_seen     = 0;
    int cfg_writes     = 0;
    int idle_cycles    = 0;

    direct_form_two_iir_filter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Fixed-point filter step: feedback sum, reciprocal scale, feedforward sum, rounding, saturation, delay update.
    function automatic t_result predict_sample(input logic [SAMP_W-1:0] smp);
        longint  acc;
        longint  w;
        longint  y;
        t_result res;
        res.clip = 1'b0;
        acc = longint'($signed(smp)) * 64'sd16384;
        acc = acc - coef_reg[REG_A1] * dly_line[0] - coef_reg[REG_A2] * dly_line[1];
        w = (acc * coef_reg[REG_INV_A0] + (64'sd1 <<< 27)) >>> 28;
        if (w > W_MAX) begin
            w = W_MAX;
            res.clip = 1'b1;
        end else if (w < W_MIN) begin
            w = W_MIN;
            res.clip = 1'b1;
        end
        y = coef_reg[REG_B0] * w + coef_reg[REG_B1] * dly_line[0]
            + coef_reg[REG_B2] * dly_line[1];
        y = (y + (64'sd1 <<< 13)) >>> 14;
        if (y > Y_MAX) begin
            y = Y_MAX;
            res.clip = 1'b1;
        end else if (y < Y_MIN) begin
            y = Y_MIN;
            res.clip = 1'b1;
        end
        dly_line[1] = dly_line[0];
        dly_line[0] = w;
        res.sample = y[SAMP_W-1:0];
        return res;
    endfunction

    // Called right after a rising edge; leaves the sender valid high on accept.
    task automatic send_sample(input logic [SAMP_W-1:0] smp, input bit has_exp,
                               input t_result exp);
        t_result res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        res = predict_sample(smp);
        expected_results.insert(expected_results.size(), has_exp ? exp : res);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx < REG_COUNT) begin
            coef_reg[idx] = longint'($signed(val));
        end
        cfg_writes++;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    function automatic void cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        t_step r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = COEF_W'(val);
        dir_tbl.insert(dir_tbl.size(), r);
    endfunction

    function automatic void smp_row(input int smp, input bit has_exp, input int y,
                                    input bit clip);
        t_step r;
        r = '0;
        r.smp = SAMP_W'(smp);
        r.has_exp = has_exp;
        r.exp.sample = SAMP_W'(y);
        r.exp.clip = clip;
        dir_tbl.insert(dir_tbl.size(), r);
    endfunction

    function automatic logic [SAMP_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return SAMP_W'($urandom_range(3)) - 16'd1;
            default: return SAMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef(input int style,
                                                    input logic [CFG_IDX_W-1:0] idx);
        int v;
        case (style)
            STYLE_MILD: begin
                if (idx == REG_INV_A0) v = $urandom_range(20000, 12000);
                else if (idx == REG_A2) v = int'($urandom_range(16000)) - 8000;
                else v = int'($urandom_range(32000)) - 16000;
            end
            STYLE_EDGE: begin
                case ($urandom_range(3))
                    0: v = -131072;
                    1: v = 131071;
                    2: v = 0;
                    default: v = 16384;
                endcase
            end
            STYLE_FULL: v = int'($urandom);
            default: v = 0;
        endcase
        return COEF_W'(v);
    endfunction

    // Output side: random or long stalls, counted here.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_done != hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_done = hold_done + 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser) clips_seen++;
            if (expected_results.size() == 0) begin
                note_error($sformatf("unexpected item: sample %h clip %b",
                                     m_axis_tdata, m_axis_tuser));
            end else begin
                exp = expected_results.pop_front();
                if (m_axis_tdata !== exp.sample || m_axis_tuser !== exp.clip) begin
                    note_error($sformatf("item %0d: expected sample %h clip %b, got %h clip %b",
                                         results_seen, exp.sample, exp.clip,
                                         m_axis_tdata, m_axis_tuser));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_wr_en) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no activity for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int     mode;
        int     style;
        t_step  r;
        t_result none;
        none = '0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;

        coef_reg[REG_INV_A0] = 16384;
        coef_reg[REG_A1]     = 0;
        coef_reg[REG_A2]     = 0;
        coef_reg[REG_B0]     = 16384;
        coef_reg[REG_B1]     = 0;
        coef_reg[REG_B2]     = 0;
        dly_line[0] = 0;
        dly_line[1] = 0;

        // pass-through after reset
        smp_row(0, 1, 0, 0);
        smp_row(32767, 1, 32767, 0);
        smp_row(-32768, 1, -32768, 0);
        smp_row(1, 1, 1, 0);
        smp_row(-1, 1, -1, 0);
        smp_row(21845, 1, 21845, 0);
        smp_row(-21846, 1, -21846, 0);
        // largest gain saturates the output
        cfg_row(REG_B0, 131071);
        smp_row(32767, 1, 32767, 1);
        smp_row(-32768, 1, -32768, 1);
        smp_row(0, 1, 0, 0);
        cfg_row(REG_B0, -131072);
        smp_row(1, 0, 0, 0);
        smp_row(-32768, 1, 32767, 1);
        // zero reciprocal: output from the delay line only
        cfg_row(REG_INV_A0, 0);
        cfg_row(REG_B0, 16384);
        cfg_row(REG_B1, 131071);
        cfg_row(REG_B2, -131072);
        smp_row(1234, 0, 0, 0);
        smp_row(-5, 0, 0, 0);
        // extreme feedback drives the delay values into saturation
        cfg_row(REG_A1, -131072);
        cfg_row(REG_A2, 131071);
        cfg_row(REG_INV_A0, 131071);
        smp_row(32767, 0, 0, 0);
        smp_row(32767, 0, 0, 0);
        smp_row(-32768, 0, 0, 0);
        smp_row(100, 0, 0, 0);
        // writes past the last register are ignored
        cfg_row(IDX_SPARE_LO, 16384);
        cfg_row(IDX_SPARE_HI, -1);
        smp_row(42, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[k]) begin
            r = dir_tbl[k];
            if (r.is_cfg) begin
                wait_drained();
                cfg_write(r.idx, r.val);
            end else begin
                send_sample(r.smp, r.has_exp, r.exp);
            end
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_drained();
            mode  = ph % 5;
            style = ph % 3;
            for (int i = 0; i < REG_COUNT; i++) begin
                cfg_write(CFG_IDX_W'(i), rand_coef(style, CFG_IDX_W'(i)));
            end
            if ($urandom_range(1)) begin
                cfg_write($urandom_range(1) ? IDX_SPARE_LO : IDX_SPARE_HI, COEF_W'($urandom));
            end
            case (mode)
                1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
                3: begin src_idle_pct = 34; sink_stall_pct = 34; end
                default: begin src_idle_pct = 0; sink_stall_pct = 0; end
            endcase
            if (mode == 4) hold_req = hold_req + 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(rand_sample(), 1'b0, none);
            end
        end

        src_idle_pct = 0;
        sink_stall_pct = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            note_error($sformatf("%0d expected items never arrived", expected_results.size()));
        end

        $display("Covered %0d samples over %0d coefficient phases with %0d register writes,",
                 items_sent, PHASE_COUNT + 1, cfg_writes);
        $display("%0d output items checked, %0d of them clipped; %0d errors.",
                 results_seen, clips_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
